### hw/rtl/sat_pkg.sv
// ============================================================================
// sat_pkg: shared types and constants for the sorted array table
// Table geometry, request and status codes, and the binary search midpoint.
// ============================================================================
package sat_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 32;
    localparam int OP_W  = 2;
    localparam int ST_W  = 2;
    localparam int CAP_W = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    typedef enum logic [OP_W-1:0] {
        OP_SEARCH = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    // floor((lo + hi) / 2) with hi kept as hi + 1; only called with lo < hi_p1
    function automatic logic [IDX_W-1:0] mid_of(input logic [CNT_W-1:0] lo,
                                                input logic [CNT_W-1:0] hi_p1);
        logic [CNT_W:0] sum;
        sum = {1'b0, lo} + {1'b0, hi_p1} - (CNT_W+1)'(1);
        return sum[IDX_W:1];
    endfunction

endpackage

### hw/rtl/sat_ram.sv
// ============================================================================
// sat_ram: simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// ============================================================================
module sat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/sorted_array_table_top.sv
// ============================================================================
// sorted_array_table_top: ascending table of signed 32-bit keys
// Search, insert and remove on a sorted table kept in one entry RAM.
// ============================================================================
// Search: a binary search of the entries in use (probes <= log2(DEPTH)+1).
// Insert: larger entries shift up from the end; remove: probes, then later
// entries shift down; one entry moves per cycle (one RAM read port).
// One beat in flight: next request taken the cycle after the result loads.
// Reset (sync, active low): count 0, capacity 64, output empty. The entry
// RAM is not cleared; only entries below the count are ever read.
module sorted_array_table_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // capacity register
    input  logic                               i_cfg_we,
    input  logic [sat_pkg::CAP_W-1:0]          i_cfg_data,
    // request channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [sat_pkg::OP_W-1:0]           i_operation,
    input  logic signed [sat_pkg::VAL_W-1:0]   i_value,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [sat_pkg::ST_W-1:0]           o_status,
    output logic [sat_pkg::IDX_W-1:0]          o_position,
    output logic [sat_pkg::CNT_W-1:0]          o_entry_count
);

    import sat_pkg::*;

    // One-hot sequencer states
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,  // waiting for a request beat
        S_PROBE = 6'b000010,  // binary search, one probe per cycle
        S_INS   = 6'b000100,  // insert: shift larger entries up
        S_PUT   = 6'b001000,  // insert: key lands at index 0
        S_REM   = 6'b010000,  // remove: shift later entries down
        S_DONE  = 6'b100000   // hand result to the output register
    } t_state;

    t_state                  r_state, n_state;
    logic [CAP_W-1:0]        r_cap;
    logic [CNT_W-1:0]        r_count, n_count;
    logic signed [VAL_W-1:0] r_key, n_key;
    logic                    r_search, n_search;   // search (else remove) in PROBE
    logic [CNT_W-1:0]        r_lo, n_lo;
    logic [CNT_W-1:0]        r_hi_p1, n_hi_p1;     // high bound plus one
    logic [IDX_W-1:0]        r_mid, n_mid;         // address of the probe in flight
    logic [IDX_W-1:0]        r_idx, n_idx;         // hole (insert) / target (remove)
    t_status                 r_status, n_status;
    logic [IDX_W-1:0]        r_pos, n_pos;

    // output register
    logic                    r_out_vld, n_out_vld;
    t_status                 r_o_status, n_o_status;
    logic [IDX_W-1:0]        r_o_pos, n_o_pos;
    logic [CNT_W-1:0]        r_o_cnt, n_o_cnt;

    // entry RAM port
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [VAL_W-1:0]        ram_wdata;
    logic [IDX_W-1:0]        ram_raddr;
    logic [VAL_W-1:0]        ram_rdata;
    logic signed [VAL_W-1:0] rd;

    logic in_acc;
    logic full;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign rd         = $signed(ram_rdata);

    // Capacity above DEPTH acts as DEPTH; count never passes DEPTH.
    assign full = (int'(r_count) >= int'(r_cap)) || (int'(r_count) >= DEPTH);

    sat_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_key     = r_key;
        n_search  = r_search;
        n_lo      = r_lo;
        n_hi_p1   = r_hi_p1;
        n_mid     = r_mid;
        n_idx     = r_idx;
        n_status  = r_status;
        n_pos     = r_pos;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = r_key;
        ram_raddr = r_mid;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_key    = i_value;
                    n_status = ST_OK;
                    n_pos    = '0;
                    n_search = (i_operation == OP_SEARCH);
                    unique case (i_operation)
                        OP_SEARCH, OP_REMOVE: begin
                            if (r_count == '0) begin
                                n_status = ST_MISSING;
                                n_state  = S_DONE;
                            end else begin
                                // first probe issued right away
                                n_lo      = '0;
                                n_hi_p1   = r_count;
                                n_mid     = mid_of('0, r_count);
                                ram_raddr = n_mid;
                                n_state   = S_PROBE;
                            end
                        end
                        OP_INSERT: begin
                            if (full) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else if (r_count == '0) begin
                                ram_we    = 1'b1;
                                ram_waddr = '0;
                                ram_wdata = i_value;
                                n_count   = r_count + CNT_W'(1);
                                n_state   = S_DONE;
                            end else begin
                                // hole at count, read the last entry
                                n_idx     = IDX_W'(r_count);
                                ram_raddr = IDX_W'(r_count - CNT_W'(1));
                                n_state   = S_INS;
                            end
                        end
                        default: begin
                            // unused code: no change, plain ok
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_PROBE: begin
                if (rd == r_key) begin
                    if (r_search) begin
                        n_pos   = r_mid;
                        n_state = S_DONE;
                    end else if ((CNT_W'(r_mid) + CNT_W'(1)) < r_count) begin
                        n_idx     = r_mid;
                        ram_raddr = r_mid + IDX_W'(1);
                        n_state   = S_REM;
                    end else begin
                        n_count = r_count - CNT_W'(1);
                        n_state = S_DONE;
                    end
                end else begin
                    if (rd < r_key) begin
                        n_lo = CNT_W'(r_mid) + CNT_W'(1);
                    end else begin
                        n_hi_p1 = CNT_W'(r_mid);
                    end
                    if (n_lo < n_hi_p1) begin
                        n_mid     = mid_of(n_lo, n_hi_p1);
                        ram_raddr = n_mid;
                    end else begin
                        n_status = ST_MISSING;
                        n_state  = S_DONE;
                    end
                end
            end

            S_INS: begin
                // rd holds entry[r_idx - 1]; writes stay above the next read
                ram_we = 1'b1;
                if (rd > r_key) begin
                    ram_wdata = ram_rdata;
                    n_idx     = r_idx - IDX_W'(1);
                    if (r_idx == IDX_W'(1)) begin
                        n_state = S_PUT;
                    end else begin
                        ram_raddr = r_idx - IDX_W'(2);
                    end
                end else begin
                    n_count = r_count + CNT_W'(1);
                    n_state = S_DONE;
                end
            end

            S_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                n_count   = r_count + CNT_W'(1);
                n_state   = S_DONE;
            end

            S_REM: begin
                // rd holds entry[r_idx + 1]
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                if ((CNT_W'(r_idx) + CNT_W'(2)) < r_count) begin
                    n_idx     = r_idx + IDX_W'(1);
                    ram_raddr = r_idx + IDX_W'(2);
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register: loaded from DONE once the previous beat is gone.
    always_comb begin
        n_out_vld  = r_out_vld && !i_out_ready;
        n_o_status = r_o_status;
        n_o_pos    = r_o_pos;
        n_o_cnt    = r_o_cnt;
        if ((r_state == S_DONE) && (!r_out_vld || i_out_ready)) begin
            n_out_vld  = 1'b1;
            n_o_status = r_status;
            n_o_pos    = r_pos;
            n_o_cnt    = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cap     <= CAP_RESET;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_search   <= n_search;
        r_lo       <= n_lo;
        r_hi_p1    <= n_hi_p1;
        r_mid      <= n_mid;
        r_idx      <= n_idx;
        r_status   <= n_status;
        r_pos      <= n_pos;
        r_o_status <= n_o_status;
        r_o_pos    <= n_o_pos;
        r_o_cnt    <= n_o_cnt;
    end

    assign o_out_valid   = r_out_vld;
    assign o_status      = r_o_status;
    assign o_position    = r_o_pos;
    assign o_entry_count = r_o_cnt;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // Count stays within the table.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= DEPTH)
        else $error("entry count above table depth");

    // A refused insert goes straight to the result with table-full status.
    a_full_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_operation == OP_INSERT) && full)
        |=> ((r_state == S_DONE) && (r_status == ST_FULL) && $stable(r_count)))
        else $error("insert on a full table not refused");

    // Shifts never write at or beyond the count (the insert hole excepted).
    a_write_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ({1'b0, ram_waddr} <= r_count))
        else $error("entry write outside the used range");

    // Count moves by at most one per cycle.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> ((r_count == $past(r_count) + CNT_W'(1)) ||
                                (r_count == $past(r_count) - CNT_W'(1))))
        else $error("entry count jumped");

endmodule

### test/sorted_array_table_top_test.sv
// ============================================================================
// sorted_array_table_top_test: self-checking bench for the sorted array table
// Feeds search, insert and remove requests through the valid/ready request
// channel, tracks the table contents and count alongside the block, and
// checks every result beat (status, position, count) in order. Capacity is
// changed between phases while the block is idle.
// ============================================================================
module sorted_array_table_top_test;
    import sat_pkg::*;

    localparam int          LIMIT_CYCLES = 1_000_000;
    localparam int          PHASE_ITEMS  = 210;
    localparam int          POOL_SIZE    = 16;
    localparam int          DRAIN_CYCLES = DEPTH + 16;
    localparam int          HOLD_CYCLES  = 400;
    // the request field is two bits wide; code 3 is unused and must be a no-op
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    localparam logic signed [VAL_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [VAL_W-1:0]  key;
    } request_t;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [IDX_W-1:0] pos;
        logic [CNT_W-1:0] count;
    } reply_t;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [CAP_W-1:0]          cfg_data  = '0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    logic [OP_W-1:0]           in_op     = '0;
    logic signed [VAL_W-1:0]   in_value  = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [ST_W-1:0]           out_status;
    logic [IDX_W-1:0]          out_pos;
    logic [CNT_W-1:0]          out_count;

    sorted_array_table_top dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_operation   (in_op),
        .i_value       (in_value),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_status      (out_status),
        .o_position    (out_pos),
        .o_entry_count (out_count)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    request_t                  queued_reqs[$];    // requests not yet offered
    reply_t                    awaited_replies[$]; // predicted, not yet seen
    bit                        beat_taken  = 1'b0; // request beat accepted at last rise
    bit                        calm        = 1'b0; // no random idling this phase
    int                        gap_left    = 0;
    int                        stall_left  = 0;
    int                        hold_left   = 0;
    int                        holds_done  = 0;
    int                        n_replies   = 0;
    int                        n_bad       = 0;
    int                        cycle_cnt   = 0;

    // Shadow of the table: sorted keys, entries in use, capacity register
    logic signed [VAL_W-1:0]   keys [DEPTH];
    int                        n_keys    = 0;
    logic [CAP_W-1:0]          cap_shadow = CAP_RESET;

    // ------------------------------------------------------------------------
    // Clock: period 12
    // ------------------------------------------------------------------------
    initial begin
        forever #6 clk = ~clk;
    end

    // Timeout: generous against the slowest legal run (the longest items plus
    // long gaps and stalls on both sides, plus the forced holds)
    initial begin
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("sorted_array_table_top_test: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Table predictor
    // ------------------------------------------------------------------------
    // Binary search over the entries in use, midpoint floor((lo+hi)/2).
    // With duplicates the first equal entry probed wins.
    function automatic bit locate_key(input logic signed [VAL_W-1:0] key, output int at);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = n_keys - 1;
        at = 0;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (keys[mid] == key) begin
                at = mid;
                return 1'b1;
            end
            if (keys[mid] < key) lo = mid + 1;
            else                 hi = mid - 1;
        end
        return 1'b0;
    endfunction

    function automatic reply_t apply_request(input request_t req);
        reply_t r;
        int     at;
        int     cap;
        int     i;
        r.status = ST_OK;
        r.pos    = '0;
        case (req.op)
            OP_SEARCH: begin
                if (locate_key(req.key, at)) r.pos = IDX_W'(at);
                else                         r.status = ST_MISSING;
            end
            OP_INSERT: begin
                // capacity above the table depth saturates at the depth
                cap = (int'(cap_shadow) > DEPTH) ? DEPTH : int'(cap_shadow);
                if (n_keys >= cap) begin
                    r.status = ST_FULL;
                end else begin
                    // new key lands after any equal keys
                    i = n_keys;
                    while (i > 0 && keys[i-1] > req.key) begin
                        keys[i] = keys[i-1];
                        i--;
                    end
                    keys[i] = req.key;
                    n_keys++;
                end
            end
            OP_REMOVE: begin
                if (locate_key(req.key, at)) begin
                    for (i = at; i + 1 < n_keys; i++) keys[i] = keys[i+1];
                    n_keys--;
                end else begin
                    r.status = ST_MISSING;
                end
            end
            default: ; // unused code: no change, status ok
        endcase
        r.count = CNT_W'(n_keys);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: samples on the rising edge. Predicts on every accepted
    // request beat, checks every accepted result beat in order.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        reply_t got;
        reply_t want;
        if (rst_n) begin
            if (cfg_we) cap_shadow = cfg_data;
            if (in_valid && in_ready) begin
                awaited_replies.push_back(apply_request('{in_op, in_value}));
                beat_taken = 1'b1;
            end
            if (out_valid && out_ready) begin
                n_replies++;
                got = '{out_status, out_pos, out_count};
                if (awaited_replies.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("[%0t] unexpected result beat: status %0d pos %0d count %0d",
                                 $realtime, got.status, got.pos, got.count);
                end else begin
                    want = awaited_replies.pop_front();
                    if (got != want) begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display({"[%0t] result %0d mismatch: expected status %0d pos %0d",
                                      " count %0d, got status %0d pos %0d count %0d"},
                                     $realtime, n_replies, want.status, want.pos, want.count,
                                     got.status, got.pos, got.count);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Idle lengths: mostly short, now and then long
    // ------------------------------------------------------------------------
    function automatic int pick_idle();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: changes inputs on the falling edge. Holds a beat until it is
    // taken, then either idles for the chosen gap or offers the next one.
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        request_t nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || beat_taken) begin
            beat_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (queued_reqs.size() > 0) begin
                nxt       = queued_reqs.pop_front();
                in_op    <= nxt.op;
                in_value <= nxt.key;
                in_valid <= 1'b1;
                gap_left  = (calm || $urandom_range(0, 1)) ? 0 : pick_idle();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side ready. Twice in the run the receiver holds off for a long
    // stretch while requests keep coming, so the block backs up and drops
    // its request ready.
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (holds_done < 2 && n_replies >= 400 + 800 * holds_done) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_idle();
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_req(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] key);
        queued_reqs.push_back('{op, key});
    endtask

    // Wait until every request is offered and taken and every result is in.
    task automatic wait_idle();
        while (queued_reqs.size() != 0 || in_valid || awaited_replies.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= cap;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic signed [VAL_W-1:0] pool [POOL_SIZE];
        logic [CAP_W-1:0]        phase_caps [8];
        logic signed [VAL_W-1:0] k;
        int                      pick;

        phase_caps = '{7'd127, 7'd64, 7'd0, 7'd1, 7'd3, 7'd20, 7'd64, 7'd64};
        phase_caps[7] = CAP_W'($urandom_range(1, 126));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // -- directed: empty table, unused code, extremes, duplicates --------
        push_req(OP_SEARCH, 32'sd0);          // search on empty table
        push_req(OP_REMOVE, 32'sd5);          // remove on empty table
        push_req(OP_SPARE,  -32'sd1);
        push_req(OP_INSERT, KEY_MIN);
        push_req(OP_INSERT, KEY_MAX);
        push_req(OP_INSERT, 32'sd0);
        push_req(OP_INSERT, 32'sd0);          // duplicate goes after its twin
        push_req(OP_INSERT, -32'sd1);
        push_req(OP_INSERT, 32'sd7);
        push_req(OP_INSERT, 32'sd0);
        push_req(OP_SEARCH, KEY_MIN);
        push_req(OP_SEARCH, KEY_MAX);
        push_req(OP_SEARCH, 32'sd0);          // which duplicate is probed first
        push_req(OP_SEARCH, 32'sd3);          // absent key
        push_req(OP_REMOVE, 32'sd0);
        push_req(OP_REMOVE, 32'sd100);        // absent key
        push_req(OP_REMOVE, KEY_MAX);
        push_req(OP_SPARE,  32'sh5555_5555);
        wait_idle();

        // capacity dropped below the count: inserts refused, entries kept
        write_capacity(7'd2);
        push_req(OP_INSERT, 32'sd9);
        push_req(OP_REMOVE, -32'sd1);
        push_req(OP_SEARCH, 32'sd7);
        wait_idle();

        // capacity zero: every insert refused
        write_capacity(7'd0);
        push_req(OP_INSERT, 32'sd1);
        wait_idle();

        // -- random phases ---------------------------------------------------
        // Keys come mostly from a small per-phase pool so that searches and
        // removes hit and duplicates pile up; a slice of fresh random keys
        // adds misses.
        for (int ph = 0; ph < 8; ph++) begin
            calm = (ph % 3 == 2);
            write_capacity(phase_caps[ph]);
            for (int i = 0; i < POOL_SIZE; i++) begin
                case ($urandom_range(0, 9))
                    0:       pool[i] = $urandom_range(0, 1) ? KEY_MIN : KEY_MAX;
                    1, 2:    pool[i] = $urandom;
                    default: pool[i] = $signed(32'($urandom_range(0, 12))) - 32'sd6;
                endcase
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                k    = ($urandom_range(0, 9) == 0) ? $urandom
                                                   : pool[$urandom_range(0, POOL_SIZE - 1)];
                pick = $urandom_range(0, 99);
                if (pick < 45)      push_req(OP_INSERT, k);
                else if (pick < 70) push_req(OP_REMOVE, k);
                else if (pick < 96) push_req(OP_SEARCH, k);
                else                push_req(OP_SPARE, k);
            end
            wait_idle();
        end

        // let any stray beat show up before judging
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_bad == 0 && awaited_replies.size() == 0)
            $display("sorted_array_table_top_test: done, clean");
        else
            $display("sorted_array_table_top_test: done, errors");
        $finish;
    end

endmodule
